[rtl/tlfd_pkg.sv]
package tlfd_pkg;

    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_W      = 3;
    localparam int LEN_W          = 16;
    localparam int TYPE_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int HDR_BYTES      = 4;
    localparam int CNT_W          = 3;
    localparam int NUM_TYPES_DEF  = 7;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [LEN_W-1:0] LEN_RESET [NUM_REGS] = '{
        16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0
    };

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TYPE_W-1:0]  ftype;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   index;
        logic               last;
    } res_t;

endpackage

[rtl/tlfd_front.sv]
module tlfd_front
    import tlfd_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 full,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output logic                 push,
    output res_t                 res
);

    logic [LEN_W-1:0]  len_reg [NUM_REGS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       store_reg, store_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;

    logic              take;
    logic [31:0]       shifted;
    logic [TYPE_W-1:0] ftype;
    logic [LEN_W-1:0]  flen;
    logic [LEN_W-1:0]  sel_len;
    logic              type_ok;

    assign take    = in_valid && !full;
    assign shifted = {store_reg[23:0], rx_byte};
    assign ftype   = shifted[31:16];
    assign flen    = shifted[15:0];
    assign type_ok = ftype < TYPE_W'(NUM_TYPES);

    always_comb
    begin
        sel_len = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (ftype[REG_IDX_W-1:0] == REG_IDX_W'(i))
            begin
                sel_len = len_reg[i];
            end
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        store_next = store_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        push       = 1'b0;
        res        = '0;
        if (take && !err_reg)
        begin
            if (cnt_reg != CNT_W'(HDR_BYTES))
            begin
                store_next = shifted;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HDR_BYTES - 1))
                begin
                    if (!type_ok || flen != sel_len)
                    begin
                        err_next  = 1'b1;
                        push      = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.ftype = ftype;
                        res.last  = 1'b1;
                    end
                    else if (flen == '0)
                    begin
                        cnt_next  = '0;
                        rem_next  = '0;
                        pos_next  = '0;
                        push      = 1'b1;
                        res.kind  = KIND_EMPTY;
                        res.ftype = ftype;
                        res.last  = 1'b1;
                    end
                    else
                    begin
                        rem_next = flen;
                        pos_next = '0;
                    end
                end
            end
            else
            begin
                rem_next  = rem_reg - 1'b1;
                pos_next  = pos_reg + 1'b1;
                push      = 1'b1;
                res.kind  = KIND_PAYLOAD;
                res.ftype = store_reg[31:16];
                res.data  = rx_byte;
                res.index = pos_reg;
                res.last  = (rem_reg == LEN_W'(1));
                if (rem_reg == LEN_W'(1))
                begin
                    cnt_next = '0;
                    pos_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                len_reg[i] <= LEN_RESET[i];
            end
            cnt_reg   <= '0;
            store_reg <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (cfg_write && cfg_index == REG_IDX_W'(i))
                begin
                    len_reg[i] <= cfg_data;
                end
            end
            cnt_reg   <= cnt_next;
            store_reg <= store_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_quiet_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !push)
        else $error("request pushed after header error");

    a_last_restarts_header: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.kind == KIND_PAYLOAD && res.last) |=> (cnt_reg == '0))
        else $error("header gather did not restart after last payload byte");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != CNT_W'(HDR_BYTES)) |-> (rem_reg == '0 || err_reg ||
            cnt_reg == '0 || cnt_reg == CNT_W'(1) || cnt_reg == CNT_W'(2) ||
            cnt_reg == CNT_W'(3)))
        else $error("header count out of range");
`endif

endmodule

[rtl/tlfd_queue.sv]
module tlfd_queue
    import tlfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t wr_data,
    input  logic pop,
    output res_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("request popped from empty queue");
`endif

endmodule

[rtl/tlfd_back.sv]
module tlfd_back
    import tlfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic empty,
    input  res_t rd_data,
    output logic pop,
    input  logic out_stall,
    output logic out_valid,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign pop        = !empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/typed_length_frame_deframer_core.sv]
// Each result passes from the header parser into the result queue and then into a registered output stage.
// One byte per cycle while the result queue is not full; header parse and result queue work in parallel.
// Input stalls only while the result queue (2 entries by default) is full.
// Reset (async, active low): header gather restarts, error flag clears,
// payload length registers return to defaults (type 2 = 2, others 0).
module typed_length_frame_deframer_core
    import tlfd_pkg::*;
#(
    parameter int NUM_TYPES   = NUM_TYPES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [TYPE_W-1:0]    frame_type,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic [LEN_W-1:0]     byte_index,
    output logic                 frame_last
);

    logic push, pop, full, empty;
    res_t wr_res, rd_res, out_res;

    assign in_stall = full;

    tlfd_front #(
        .NUM_TYPES (NUM_TYPES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .res       (wr_res)
    );

    tlfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_res),
        .pop     (pop),
        .rd_data (rd_res),
        .full    (full),
        .empty   (empty)
    );

    tlfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .rd_data   (rd_res),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign frame_type   = out_res.ftype;
    assign payload_byte = out_res.data;
    assign byte_index   = out_res.index;
    assign frame_last   = out_res.last;

endmodule

[dv/typed_length_frame_deframer_core_tb.sv]
import tlfd_pkg::*;

class deframe_tracker;
    logic [LEN_W-1:0]  type_len [NUM_REGS];
    logic [CNT_W-1:0]  hdr_count;
    logic [31:0]       hdr_bytes;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  position;
    bit                locked_out;
    res_t              results_due [$];
    int                mismatches;
    int                bytes_taken;
    int                payload_count;
    int                empty_count;
    int                error_count;

    function new();
        for (int i = 0; i < NUM_REGS; i++)
            type_len[i] = LEN_RESET[i];
        hdr_count = '0;
        hdr_bytes = '0;
        remaining = '0;
        position = '0;
        locked_out = 1'b0;
        mismatches = 0;
        bytes_taken = 0;
        payload_count = 0;
        empty_count = 0;
        error_count = 0;
    endfunction

    function void write_len(int idx, logic [LEN_W-1:0] value);
        if (idx < NUM_REGS)
            type_len[idx] = value;
    endfunction

    function int pending();
        return results_due.size();
    endfunction

    function void take_byte(logic [BYTE_W-1:0] rx);
        res_t r;
        logic [TYPE_W-1:0] ftype;
        logic [LEN_W-1:0] flen;
        if (locked_out)
            return;
        bytes_taken++;
        r = '0;
        ftype = hdr_bytes[31:16];
        if (hdr_count < HDR_BYTES)
        begin
            hdr_bytes = {hdr_bytes[23:0], rx};
            hdr_count = hdr_count + 1'b1;
            if (hdr_count < HDR_BYTES)
                return;
            ftype = hdr_bytes[31:16];
            flen = hdr_bytes[15:0];
            r.ftype = ftype;
            r.last = 1'b1;
            if (ftype >= NUM_TYPES_DEF)
                locked_out = 1'b1;
            else if (flen != type_len[ftype])
                locked_out = 1'b1;
            if (locked_out)
            begin
                r.kind = KIND_ERROR;
                results_due.push_back(r);
                return;
            end
            position = '0;
            remaining = flen;
            if (flen == 0)
            begin
                hdr_count = '0;
                r.kind = KIND_EMPTY;
                results_due.push_back(r);
            end
            return;
        end
        r.kind = KIND_PAYLOAD;
        r.ftype = ftype;
        r.data = rx;
        r.index = position;
        remaining = remaining - 1'b1;
        position = position + 1'b1;
        r.last = (remaining == 0);
        if (r.last)
        begin
            hdr_count = '0;
            position = '0;
        end
        results_due.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(res_t got);
        res_t want;
        if (results_due.size() == 0)
        begin
            $error("result with nothing expected: kind %0d type %0d", got.kind, got.ftype);
            mismatches++;
            return;
        end
        want = results_due.pop_front();
        field_check("result_kind", want.kind, got.kind);
        field_check("frame_type", want.ftype, got.ftype);
        field_check("payload_byte", want.data, got.data);
        field_check("byte_index", want.index, got.index);
        field_check("frame_last", want.last, got.last);
        case (want.kind)
            KIND_PAYLOAD: payload_count++;
            KIND_EMPTY:   empty_count++;
            default:      error_count++;
        endcase
    endfunction
endclass

module typed_length_frame_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tlfd_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 600;
    localparam int FRAME_LEN_CAP = 64;
    localparam int BIG_FRAME_LEN = 300;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_ALT    = 3;

    localparam int SET_RANDOM  = 0;
    localparam int SET_ZERO    = 1;
    localparam int SET_EXTREME = 2;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 cfg_write = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           result_kind;
    logic [TYPE_W-1:0]    frame_type;
    logic [BYTE_W-1:0]    payload_byte;
    logic [LEN_W-1:0]     byte_index;
    logic                 frame_last;

    deframe_tracker tracker = new();
    int unsigned cycles = 0;
    int stall_pct = 0;
    int stall_run = 0;
    bit gaps_on = 1'b0;
    int settings_used = 0;
    int longest_frame = 0;
    logic [LEN_W-1:0] next_len [NUM_REGS];

    typed_length_frame_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .frame_type   (frame_type),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .frame_last   (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int run_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 25);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        if (cycles % 400 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
        end
        if (stall_run > 0)
            stall_run = stall_run - 1;
        else
        begin
            stall_run = run_length();
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(res_t'({result_kind, frame_type, payload_byte,
                                         byte_index, frame_last}));
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LEN_W-1:0] random_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 80)
            return LEN_W'($urandom_range(1, 8));
        if (r < 95)
            return LEN_W'($urandom_range(9, 24));
        return LEN_W'($urandom_range(25, FRAME_LEN_CAP));
    endfunction

    function automatic void choose_lengths(int style);
        int keep;
        keep = $urandom_range(0, NUM_REGS - 1);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (style)
                SET_ZERO:    next_len[i] = '0;
                SET_EXTREME: next_len[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default:     next_len[i] = random_len();
            endcase
        end
        if (next_len[keep] > FRAME_LEN_CAP)
            next_len[keep] = random_len();
    endfunction

    task automatic program_lengths();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data <= next_len[i];
            @(posedge clk);
            tracker.write_len(i, next_len[i]);
        end
        // index past the last length register: request must be ignored
        cfg_index <= REG_IDX_W'(NUM_REGS);
        cfg_data <= LEN_W'($urandom);
        @(posedge clk);
        tracker.write_len(NUM_REGS, cfg_data);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        int gap;
        rx_byte <= rx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_byte(rx);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_header(input logic [TYPE_W-1:0] ftype, input logic [LEN_W-1:0] flen);
        send_byte(ftype[TYPE_W-1:8]);
        send_byte(ftype[7:0]);
        send_byte(flen[LEN_W-1:8]);
        send_byte(flen[7:0]);
    endtask

    task automatic send_frame(input logic [TYPE_W-1:0] ftype, input logic [LEN_W-1:0] flen,
                              input int fill);
        logic [BYTE_W-1:0] rx;
        send_header(ftype, flen);
        for (int i = 0; i < flen; i++)
        begin
            case (fill)
                FILL_ZEROS: rx = '0;
                FILL_ONES:  rx = '1;
                FILL_ALT:   rx = (i % 2 == 0) ? '0 : '1;
                default:    rx = BYTE_W'($urandom);
            endcase
            send_byte(rx);
        end
        if (int'(flen) > longest_frame)
            longest_frame = int'(flen);
    endtask

    task automatic send_random_frame();
        int ftype;
        int fill;
        ftype = $urandom_range(0, NUM_TYPES_DEF - 1);
        while (next_len[ftype] > FRAME_LEN_CAP)
            ftype = (ftype + 1) % NUM_TYPES_DEF;
        case ($urandom_range(0, 9))
            0:       fill = FILL_ZEROS;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
        endcase
        send_frame(TYPE_W'(ftype), next_len[ftype], fill);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int items_at_start;
        int phase_end;
        int phase;
        int style;
        int big_type;
        logic [TYPE_W-1:0] bad_type;
        logic [LEN_W-1:0] bad_len;
        int fails;

        for (int i = 0; i < NUM_REGS; i++)
            next_len[i] = LEN_RESET[i];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(16'd2, 16'd2, FILL_ALT);
        send_frame(16'd0, 16'd0, FILL_RANDOM);
        drain_results();
        next_len = '{16'd1, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
        program_lengths();
        send_frame(16'd1, 16'd3, FILL_ALT);
        send_frame(16'd6, 16'd1, FILL_ONES);
        send_frame(16'd2, 16'd0, FILL_RANDOM);
        drain_results();

        items_at_start = tracker.bytes_taken;
        phase = 0;
        while (tracker.bytes_taken - items_at_start < RANDOM_ITEMS)
        begin
            case (phase % 4)
                1:       style = SET_ZERO;
                2:       style = SET_EXTREME;
                default: style = SET_RANDOM;
            endcase
            choose_lengths(style);
            program_lengths();
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_end = tracker.bytes_taken + $urandom_range(60, 160);
            while (tracker.bytes_taken < phase_end)
                send_random_frame();
            drain_results();
            phase++;
        end

        big_type = $urandom_range(0, NUM_TYPES_DEF - 1);
        choose_lengths(SET_RANDOM);
        next_len[big_type] = LEN_W'(BIG_FRAME_LEN);
        program_lengths();
        gaps_on = 1'b0;
        send_frame(TYPE_W'(big_type), LEN_W'(BIG_FRAME_LEN), FILL_RANDOM);
        send_random_frame();
        drain_results();

        gaps_on = 1'b1;
        choose_lengths(SET_RANDOM);
        program_lengths();
        send_random_frame();
        case ($urandom_range(0, 2))
            0:
            begin
                bad_type = TYPE_W'(NUM_TYPES_DEF);
                bad_len = LEN_W'($urandom);
            end
            1:
            begin
                bad_type = '1;
                bad_len = LEN_W'($urandom);
            end
            default:
            begin
                bad_type = TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1));
                bad_len = next_len[bad_type] ^ LEN_W'($urandom_range(1, 16'hFFFF));
            end
        endcase
        send_header(bad_type, bad_len);
        repeat (24) send_byte(BYTE_W'($urandom));
        drain_results();
        repeat (10) @(posedge clk);

        fails = tracker.mismatches + tracker.pending();
        $display("Accepted %0d bytes under %0d length settings, longest frame %0d bytes.",
                 tracker.bytes_taken, settings_used, longest_frame);
        $display("Checked %0d payload bytes, %0d empty frames, %0d header errors.",
                 tracker.payload_count, tracker.empty_count, tracker.error_count);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
rtl/tlfd_pkg.sv
rtl/tlfd_front.sv
rtl/tlfd_queue.sv
rtl/tlfd_back.sv
rtl/typed_length_frame_deframer_core.sv
dv/typed_length_frame_deframer_core_tb.sv
